[src/lzss_stream_decompressor_macros.svh]
// Assertion macros shared by the decompressor RTL.
// Each macro expects clk and rst in the scope where it is used.
`ifndef LZSS_STREAM_DECOMPRESSOR_MACROS_SVH
`define LZSS_STREAM_DECOMPRESSOR_MACROS_SVH

// same-cycle implication
`define LZSD_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define LZSD_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[src/lzsd_pkg.sv]
// Package for the LZSS stream decompressor: widths, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
package lzsd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = 32;
  localparam int HDR_IDX_W    = 3;
  localparam int FLAG_W       = 9;
  localparam int LEN_W        = 5;

  typedef logic [WIN_AW-1:0]    win_addr_t;
  typedef logic [WIN_AW:0]      fill_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;
  typedef logic [FLAG_W-1:0]    flag_t;
  typedef logic [LEN_W-1:0]     len_t;

  localparam cnt_t  OUT_LIMIT_RESET = '1;
  localparam flag_t FLAG_MARK       = 9'h100;

  localparam logic [7:0] MAGIC_L = 8'h4C;
  localparam logic [7:0] MAGIC_Z = 8'h5A;
  localparam logic [7:0] MAGIC_S = 8'h53;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_HDR   = 3'd1,
    STAT_TOO_LARGE = 3'd2,
    STAT_SHORT     = 3'd3,
    STAT_LIMIT     = 3'd4
  } lzsd_status_t;

  typedef enum logic [3:0] {
    S_HDR,
    S_HDR_PROC,
    S_FLAG,
    S_FLAG_PROC,
    S_LIT,
    S_LIT_PROC,
    S_PAIR1,
    S_PAIR1_PROC,
    S_PAIR2,
    S_PAIR2_PROC,
    S_MATCH,
    S_DONE,
    S_DRAIN
  } lzsd_state_t;

  typedef struct packed {
    logic         take;
    logic         hdr_start;
    logic         hdr_magic;
    logic         hdr_size;
    logic         win_clear;
    logic         flag_load;
    logic         flag_adv;
    logic         pfb_load;
    logic         m_start;
    logic         m_push;
    logic         lit_push;
    logic         emit_status;
    logic         hidx_clr;
    lzsd_status_t code;
  } lzsd_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic lastin;
    logic magic_ok;
    logic hidx_lt4;
    logic hidx_last;
    logic exp_zero;
    logic exp_gt_limit;
    logic cnt_ge_limit;
    logic cnt_ge_exp;
    logic byte_b0;
    logic flag_done;
    logic flag_next_b0;
    logic mrem_zero;
  } lzsd_stat_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = MAGIC_L;
      2'd1:    m = MAGIC_Z;
      default: m = MAGIC_S;
    endcase
    return m;
  endfunction

endpackage

[src/lzsd_if.sv]
// Valid/ready stream interfaces for compressed input and decoded output.
// Depends on nothing.
interface lzsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_kind;
  logic [2:0]  status;
  logic [31:0] byte_count;
  logic        last;

  modport source (output valid, output out_byte, output out_kind, output status,
                  output byte_count, output last, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input status,
                  input byte_count, input last, output ready);
endinterface

[src/lzsd_ctrl.sv]
// Decoder sequencer: tracks the blob phase and issues datapath commands.
// Depends on lzsd_pkg.
module lzsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  lzsd_pkg::lzsd_stat_t stat,
  output lzsd_pkg::lzsd_cmd_t  cmd
);

  lzsd_pkg::lzsd_state_t state, state_next;
  lzsd_pkg::lzsd_status_t fin_code;
  lzsd_pkg::lzsd_state_t fin_state;
  logic fin_req;
  logic need_slot;
  logic hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzsd_pkg::S_HDR;
    end else begin
      state <= state_next;
    end
  end

  // finish decision shared by next state and outputs
  always_comb begin
    fin_req   = 1'b0;
    fin_code  = lzsd_pkg::STAT_OK;
    need_slot = 1'b0;
    case (state)
      lzsd_pkg::S_HDR_PROC: begin
        if (stat.hidx_lt4) begin
          fin_req  = !stat.magic_ok || stat.lastin;
          fin_code = lzsd_pkg::STAT_BAD_HDR;
        end else if (!stat.hidx_last) begin
          fin_req  = stat.lastin;
          fin_code = lzsd_pkg::STAT_SHORT;
        end else if (stat.exp_zero) begin
          fin_req  = 1'b1;
          fin_code = lzsd_pkg::STAT_BAD_HDR;
        end else if (stat.exp_gt_limit) begin
          fin_req  = 1'b1;
          fin_code = lzsd_pkg::STAT_TOO_LARGE;
        end else begin
          fin_req  = stat.lastin;
          fin_code = lzsd_pkg::STAT_SHORT;
        end
      end
      lzsd_pkg::S_FLAG_PROC, lzsd_pkg::S_PAIR1_PROC: begin
        fin_req  = stat.lastin;
        fin_code = lzsd_pkg::STAT_SHORT;
      end
      lzsd_pkg::S_LIT_PROC, lzsd_pkg::S_MATCH: begin
        fin_req   = stat.cnt_ge_limit;
        fin_code  = lzsd_pkg::STAT_LIMIT;
        need_slot = 1'b1;
      end
      lzsd_pkg::S_DONE: begin
        if (stat.cnt_ge_exp) begin
          fin_req  = 1'b1;
          fin_code = lzsd_pkg::STAT_OK;
        end else begin
          fin_req  = stat.lastin;
          fin_code = lzsd_pkg::STAT_SHORT;
        end
      end
      default: begin
        fin_req = 1'b0;
      end
    endcase
    hold      = (need_slot || fin_req) && !stat.slot_free;
    fin_state = stat.lastin ? lzsd_pkg::S_HDR : lzsd_pkg::S_DRAIN;
  end

  always_comb begin
    state_next = state;
    case (state)
      lzsd_pkg::S_HDR:   if (in_valid) state_next = lzsd_pkg::S_HDR_PROC;
      lzsd_pkg::S_FLAG:  if (in_valid) state_next = lzsd_pkg::S_FLAG_PROC;
      lzsd_pkg::S_LIT:   if (in_valid) state_next = lzsd_pkg::S_LIT_PROC;
      lzsd_pkg::S_PAIR1: if (in_valid) state_next = lzsd_pkg::S_PAIR1_PROC;
      lzsd_pkg::S_PAIR2: if (in_valid) state_next = lzsd_pkg::S_PAIR2_PROC;
      lzsd_pkg::S_DRAIN: if (in_valid && in_last) state_next = lzsd_pkg::S_HDR;
      lzsd_pkg::S_HDR_PROC: begin
        if (hold) state_next = state;
        else if (fin_req) state_next = fin_state;
        else if (stat.hidx_lt4 || !stat.hidx_last) state_next = lzsd_pkg::S_HDR;
        else state_next = lzsd_pkg::S_FLAG;
      end
      lzsd_pkg::S_FLAG_PROC: begin
        if (hold) state_next = state;
        else if (fin_req) state_next = fin_state;
        else state_next = stat.byte_b0 ? lzsd_pkg::S_LIT : lzsd_pkg::S_PAIR1;
      end
      lzsd_pkg::S_LIT_PROC: begin
        if (hold) state_next = state;
        else if (fin_req) state_next = fin_state;
        else state_next = lzsd_pkg::S_DONE;
      end
      lzsd_pkg::S_PAIR1_PROC: begin
        if (hold) state_next = state;
        else if (fin_req) state_next = fin_state;
        else state_next = lzsd_pkg::S_PAIR2;
      end
      lzsd_pkg::S_PAIR2_PROC: state_next = lzsd_pkg::S_MATCH;
      lzsd_pkg::S_MATCH: begin
        if (hold) state_next = state;
        else if (fin_req) state_next = fin_state;
        else if (stat.mrem_zero) state_next = lzsd_pkg::S_DONE;
        else state_next = lzsd_pkg::S_MATCH;
      end
      lzsd_pkg::S_DONE: begin
        if (hold) state_next = state;
        else if (fin_req) state_next = fin_state;
        else if (stat.flag_done) state_next = lzsd_pkg::S_FLAG;
        else state_next = stat.flag_next_b0 ? lzsd_pkg::S_LIT : lzsd_pkg::S_PAIR1;
      end
      default: state_next = lzsd_pkg::S_HDR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      lzsd_pkg::S_HDR: begin
        in_ready      = 1'b1;
        cmd.take      = in_valid;
        cmd.hdr_start = in_valid;
      end
      lzsd_pkg::S_FLAG, lzsd_pkg::S_LIT, lzsd_pkg::S_PAIR1, lzsd_pkg::S_PAIR2,
      lzsd_pkg::S_DRAIN: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      default: begin
        if (!hold) begin
          cmd.emit_status = fin_req;
          cmd.hidx_clr    = fin_req;
          cmd.code        = fin_code;
          case (state)
            lzsd_pkg::S_HDR_PROC: begin
              if (stat.hidx_lt4) begin
                cmd.hdr_magic = stat.magic_ok;
              end else begin
                cmd.hdr_size  = 1'b1;
                cmd.win_clear = stat.hidx_last && !stat.exp_zero && !stat.exp_gt_limit;
              end
            end
            lzsd_pkg::S_FLAG_PROC:  cmd.flag_load = 1'b1;
            lzsd_pkg::S_LIT_PROC:   cmd.lit_push  = !fin_req;
            lzsd_pkg::S_PAIR1_PROC: cmd.pfb_load  = 1'b1;
            lzsd_pkg::S_PAIR2_PROC: cmd.m_start   = 1'b1;
            lzsd_pkg::S_MATCH:      cmd.m_push    = !fin_req;
            lzsd_pkg::S_DONE:       cmd.flag_adv  = !fin_req;
            default:                cmd.take      = 1'b0;
          endcase
        end
      end
    endcase
  end

endmodule

[src/lzsd_datapath.sv]
// Decoder datapath: header/size registers, flag shifter, 4096-byte window,
// match copy engine and the output item register. Depends on lzsd_pkg, macros.
`include "lzss_stream_decompressor_macros.svh"

module lzsd_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  lzsd_pkg::lzsd_cmd_t  cmd,
  output lzsd_pkg::lzsd_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_kind,
  output logic [2:0]           out_status,
  output logic [31:0]          out_count,
  output logic                 out_last
);

  logic [7:0] window [lzsd_pkg::WINDOW_DEPTH];

  lzsd_pkg::cnt_t      out_limit;
  lzsd_pkg::cnt_t      count;
  lzsd_pkg::cnt_t      expected;
  lzsd_pkg::cnt_t      exp_new;
  lzsd_pkg::hdr_idx_t  hidx;
  lzsd_pkg::flag_t     flag;
  lzsd_pkg::flag_t     flag_next;
  lzsd_pkg::win_addr_t write_pos;
  lzsd_pkg::win_addr_t mpos;
  lzsd_pkg::win_addr_t rd_addr;
  lzsd_pkg::fill_t     fill;
  lzsd_pkg::len_t      mrem;
  logic [7:0]          byte_r;
  logic                last_r;
  logic [7:0]          pfb;
  logic [7:0]          rd_raw;
  logic [7:0]          rd_fdata;
  logic [7:0]          rd_byte;
  logic [7:0]          wr_data;
  logic                rd_fwd;
  logic                rd_vld;
  logic                rd_en;
  logic                wr_en;
  logic                out_load;

  assign exp_new   = {expected[23:0], byte_r};
  assign flag_next = {1'b0, flag[lzsd_pkg::FLAG_W-1:1]};
  assign rd_en     = cmd.m_start || cmd.m_push;
  assign rd_addr   = cmd.m_start ? {byte_r[7:4], pfb} : mpos + lzsd_pkg::win_addr_t'(1);
  assign wr_en     = cmd.m_push || cmd.lit_push;
  assign wr_data   = cmd.m_push ? rd_byte : byte_r;
  assign rd_byte   = rd_fwd ? rd_fdata : (rd_vld ? rd_raw : 8'h00);
  assign out_load  = wr_en || cmd.emit_status;

  always_comb begin
    stat.slot_free    = !out_valid || out_ready;
    stat.lastin       = last_r;
    stat.magic_ok     = byte_r == lzsd_pkg::magic_byte(hidx[1:0]);
    stat.hidx_lt4     = !hidx[2];
    stat.hidx_last    = &hidx;
    stat.exp_zero     = exp_new == '0;
    stat.exp_gt_limit = exp_new > out_limit;
    stat.cnt_ge_limit = count >= out_limit;
    stat.cnt_ge_exp   = count >= expected;
    stat.byte_b0      = byte_r[0];
    stat.flag_done    = flag_next <= lzsd_pkg::flag_t'(1);
    stat.flag_next_b0 = flag_next[0];
    stat.mrem_zero    = mrem == '0;
  end

  // window: read data registered, same-address write forwarded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      window[write_pos] <= wr_data;
    end
    if (rd_en) begin
      rd_raw   <= window[rd_addr];
      rd_fdata <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= lzsd_pkg::OUT_LIMIT_RESET;
      count     <= '0;
      expected  <= '0;
      hidx      <= '0;
      flag      <= '0;
      write_pos <= '0;
      fill      <= '0;
      pfb       <= '0;
      out_valid <= 1'b0;
      rd_fwd    <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        out_limit <= cfg_wr_data;
      end
      if (cmd.hdr_start && hidx == '0) begin
        count    <= '0;
        expected <= '0;
      end else if (cmd.win_clear) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + lzsd_pkg::cnt_t'(1);
      end
      if (cmd.hdr_size) begin
        expected <= exp_new;
      end
      if (cmd.hidx_clr) begin
        hidx <= '0;
      end else if (cmd.hdr_magic || cmd.hdr_size) begin
        hidx <= hidx + lzsd_pkg::hdr_idx_t'(1);
      end
      if (cmd.win_clear) begin
        flag <= '0;
      end else if (cmd.flag_load) begin
        flag <= lzsd_pkg::FLAG_MARK | {1'b0, byte_r};
      end else if (cmd.flag_adv) begin
        flag <= flag_next;
      end
      if (cmd.pfb_load) begin
        pfb <= byte_r;
      end
      if (cmd.win_clear) begin
        write_pos <= '0;
        fill      <= '0;
      end else if (wr_en) begin
        write_pos <= write_pos + lzsd_pkg::win_addr_t'(1);
        if (!fill[lzsd_pkg::WIN_AW]) begin
          fill <= fill + lzsd_pkg::fill_t'(1);
        end
      end
      if (rd_en) begin
        rd_fwd <= wr_en && write_pos == rd_addr;
        rd_vld <= fill[lzsd_pkg::WIN_AW] || rd_addr < fill[lzsd_pkg::WIN_AW-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (rd_en) begin
      mpos <= rd_addr;
    end
    // copy length minus one: (b2 & 0x0F) + 2
    if (cmd.m_start) begin
      mrem <= lzsd_pkg::len_t'(byte_r[3:0]) + lzsd_pkg::len_t'(2);
    end else if (cmd.m_push) begin
      mrem <= mrem - lzsd_pkg::len_t'(1);
    end
    if (wr_en) begin
      out_byte   <= wr_data;
      out_kind   <= 1'b0;
      out_status <= lzsd_pkg::STAT_OK;
      out_count  <= count + lzsd_pkg::cnt_t'(1);
      out_last   <= 1'b0;
    end else if (cmd.emit_status) begin
      out_byte   <= 8'h00;
      out_kind   <= 1'b1;
      out_status <= cmd.code;
      out_count  <= count;
      out_last   <= 1'b1;
    end
  end

  `LZSD_ASSERT_IMP(a_no_overwrite, out_valid && !out_ready, !out_load, "pending item overwritten")
  `LZSD_ASSERT_IMP(a_status_shape, out_valid && out_kind, out_last && out_byte == 8'h00,
                   "status item malformed")
  `LZSD_ASSERT_NXT(a_push_in_limit, wr_en, count <= out_limit, "byte pushed past output limit")

endmodule

[src/lzss_stream_decompressor.sv]
// Top level of the LZSS stream decompressor: sequencer plus datapath.
// Depends on lzsd_pkg, lzsd_if, lzsd_ctrl and lzsd_datapath.
//
// Usage: compressed bytes enter on comp (in_byte, in_last marks the blob's
// final byte); decoded items leave on decomp. Each blob yields its data bytes
// (out_kind 0) followed by one status item (out_kind 1, last 1) carrying the
// final byte_count. cfg_wr_en/cfg_wr_data load out_limit; write it only while
// the block is idle.
// Timing: an input byte is accepted, then processed in the next cycle. Header,
// flag and first pair bytes are accepted, then processed; a literal is accepted,
// emitted, then closed by a bookkeeping step. The second pair byte is accepted,
// then starts the copy; the copy pushes one copied byte (3 to 18) per cycle out
// of the window's registered read port while the output is not stalled, then a
// closing step follows. A status item is emitted by the step that raises it.
// Output: a single output register holds the next item; when the receiver
// stalls, the sequencer holds in the step that needs to emit, and input is
// not taken until that step completes.
// Reset (rst, synchronous): back to the header phase, output empty, out_limit
// all ones, window reads as zero. The window is cleared logically per blob by
// a fill count, so no clearing pass is needed.
module lzss_stream_decompressor (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  lzsd_in_if.sink           comp,
  lzsd_out_if.source        decomp
);

  lzsd_pkg::lzsd_cmd_t  cmd;
  lzsd_pkg::lzsd_stat_t stat;

  lzsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (comp.valid),
    .in_last  (comp.in_last),
    .in_ready (comp.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzsd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (comp.in_byte),
    .in_last     (comp.in_last),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (decomp.valid),
    .out_ready   (decomp.ready),
    .out_byte    (decomp.out_byte),
    .out_kind    (decomp.out_kind),
    .out_status  (decomp.status),
    .out_count   (decomp.byte_count),
    .out_last    (decomp.last)
  );

endmodule

[tb/sv/lzsd_decode_checker.sv]
// Checker for lzss_stream_decompressor: decodes each accepted input item on
// its own window copy and compares every output item, field by field.
// Depends on lzsd_pkg and the lzsd_in_if / lzsd_out_if interfaces.
module lzsd_decode_checker
  import lzsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  lzsd_in_if          comp,
  lzsd_out_if         decomp,
  output int          errors,
  output int          pending
);

  typedef enum logic [2:0] {
    DEC_HEADER,
    DEC_FLAG,
    DEC_LITERAL,
    DEC_PAIR_LO,
    DEC_PAIR_HI,
    DEC_SKIP
  } dec_phase_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [31:0] MAGIC_WORD = {MAGIC_L, MAGIC_Z, MAGIC_S, MAGIC_S};

  typedef struct packed {
    logic [7:0]   data;
    logic         kind;
    lzsd_status_t stat;
    cnt_t         count;
    logic         last;
  } dec_item_t;

  logic [7:0] window_q [WINDOW_DEPTH];
  win_addr_t  wr_pos;
  cnt_t       out_cnt;
  cnt_t       size_exp;
  cnt_t       out_limit;
  int         hdr_idx;
  flag_t      flags;
  logic [7:0] pair_lo;
  dec_phase_t dphase;
  dec_item_t  decoded_q[$];
  int         fails = 0;

  task automatic clear_window();
    for (int i = 0; i < WINDOW_DEPTH; i++) window_q[i] = 8'h00;
  endtask

  task automatic push_item(input logic [7:0] d, input logic k, input lzsd_status_t s,
                           input logic l);
    dec_item_t it;
    it.data  = d;
    it.kind  = k;
    it.stat  = s;
    it.count = out_cnt;
    it.last  = l;
    decoded_q.push_back(it);
  endtask

  task automatic close_blob(input lzsd_status_t s, input logic lastin);
    push_item(8'h00, KIND_STATUS, s, 1'b1);
    hdr_idx = 0;
    dphase  = lastin ? DEC_HEADER : DEC_SKIP;
  endtask

  task automatic emit_data(input logic [7:0] c);
    window_q[wr_pos] = c;
    wr_pos  = wr_pos + 1'b1;
    out_cnt = out_cnt + 1;
    push_item(c, KIND_DATA, STAT_OK, 1'b0);
  endtask

  task automatic item_end(input logic lastin);
    if (out_cnt >= size_exp) begin
      close_blob(STAT_OK, lastin);
    end else begin
      flags = flags >> 1;
      if (flags <= 9'd1) dphase = DEC_FLAG;
      else dphase = flags[0] ? DEC_LITERAL : DEC_PAIR_LO;
      if (lastin) close_blob(STAT_SHORT, lastin);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin : watch
    logic [7:0] b;
    logic       lin;
    win_addr_t  pos;
    int         len;
    logic       stopped;
    dec_item_t  want;
    if (rst) begin
      clear_window();
      wr_pos    = '0;
      out_cnt   = '0;
      size_exp  = '0;
      hdr_idx   = 0;
      flags     = '0;
      pair_lo   = '0;
      dphase    = DEC_HEADER;
      out_limit = OUT_LIMIT_RESET;
      decoded_q.delete();
    end else begin
      if (cfg_wr_en) out_limit = cfg_wr_data;
      if (comp.valid && comp.ready) begin
        b   = comp.in_byte;
        lin = comp.in_last;
        case (dphase)
          DEC_FLAG: begin
            flags  = FLAG_MARK | flag_t'(b);
            dphase = b[0] ? DEC_LITERAL : DEC_PAIR_LO;
            if (lin) close_blob(STAT_SHORT, lin);
          end
          DEC_LITERAL: begin
            if (out_cnt >= out_limit) begin
              close_blob(STAT_LIMIT, lin);
            end else begin
              emit_data(b);
              item_end(lin);
            end
          end
          DEC_PAIR_LO: begin
            pair_lo = b;
            dphase  = DEC_PAIR_HI;
            if (lin) close_blob(STAT_SHORT, lin);
          end
          DEC_PAIR_HI: begin
            pos     = {b[7:4], pair_lo};
            len     = int'(b[3:0]) + 3;
            stopped = 1'b0;
            for (int i = 0; i < len; i++) begin
              if (!stopped) begin
                if (out_cnt >= out_limit) begin
                  close_blob(STAT_LIMIT, lin);
                  stopped = 1'b1;
                end else begin
                  emit_data(window_q[pos + win_addr_t'(i)]);
                end
              end
            end
            if (!stopped) item_end(lin);
          end
          DEC_SKIP: begin
            if (lin) begin
              dphase  = DEC_HEADER;
              hdr_idx = 0;
            end
          end
          default: begin
            if (hdr_idx > 7) hdr_idx = 0;
            if (hdr_idx == 0) begin
              out_cnt  = '0;
              size_exp = '0;
            end
            if (hdr_idx < 4) begin
              if (b != MAGIC_WORD[31 - 8*hdr_idx -: 8]) begin
                close_blob(STAT_BAD_HDR, lin);
              end else begin
                hdr_idx++;
                if (lin) close_blob(STAT_BAD_HDR, lin);
              end
            end else begin
              size_exp = {size_exp[23:0], b};
              hdr_idx++;
              if (hdr_idx < 8) begin
                if (lin) close_blob(STAT_SHORT, lin);
              end else if (size_exp == '0) begin
                close_blob(STAT_BAD_HDR, lin);
              end else if (size_exp > out_limit) begin
                close_blob(STAT_TOO_LARGE, lin);
              end else begin
                clear_window();
                wr_pos  = '0;
                out_cnt = '0;
                flags   = '0;
                dphase  = DEC_FLAG;
                if (lin) close_blob(STAT_SHORT, lin);
              end
            end
          end
        endcase
      end
      if (decomp.valid && decomp.ready) begin
        if (decoded_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected output item, expected none, actual byte %0h kind %0b %s",
                   $time, decomp.out_byte, decomp.out_kind, "status/count/last follow");
          $display("%0t:   actual status %0d count %0d last %0b",
                   $time, decomp.status, decomp.byte_count, decomp.last);
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", 32'(want.data), 32'(decomp.out_byte));
          check_field("out_kind", 32'(want.kind), 32'(decomp.out_kind));
          check_field("status", 32'(want.stat), 32'(decomp.status));
          check_field("byte_count", want.count, decomp.byte_count);
          check_field("last", 32'(want.last), 32'(decomp.last));
        end
      end
    end
    errors  <= fails;
    pending <= decoded_q.size();
  end

endmodule

[tb/sv/lzss_stream_decompressor_tb.sv]
// Testbench top for lzss_stream_decompressor: builds compressed blobs (good,
// cut short, bad magic, zero size), drives them with random idling and gives the verdict.
// Depends on lzsd_pkg, lzsd_in_if / lzsd_out_if and lzsd_decode_checker.
module lzss_stream_decompressor_tb;
  import lzsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 250;
  localparam int SETTLE_CYCLES  = 48;
  localparam int PHASE_BYTES    = 8;
  localparam int N_PHASES       = 8;
  localparam int MAX_BODY_ITEMS = 40;

  typedef enum {BLOB_GOOD, BLOB_CUT, BLOB_BAD_MAGIC, BLOB_ZERO} blob_kind_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } comp_item_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        src_valid   = 1'b0;
  logic [7:0]  src_byte    = '0;
  logic        src_last    = 1'b0;
  logic        snk_ready   = 1'b0;
  int          src_pct     = 0;
  int          snk_pct     = 0;
  int          hold_req    = 0;
  int          hold_ack    = 0;
  int          hold_left   = 0;
  int          quiet       = 0;
  int          errors;
  int          pending;
  comp_item_t  comp_q[$];

  lzsd_in_if  comp_ch();
  lzsd_out_if decomp_ch();

  assign comp_ch.valid   = src_valid;
  assign comp_ch.in_byte = src_byte;
  assign comp_ch.in_last = src_last;
  assign decomp_ch.ready = snk_ready;

  lzss_stream_decompressor i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .comp        (comp_ch),
    .decomp      (decomp_ch)
  );

  lzsd_decode_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .comp        (comp_ch),
    .decomp      (decomp_ch),
    .errors      (errors),
    .pending     (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || comp_ch.ready) begin
      if (comp_q.size() > 0 && $urandom_range(99) >= src_pct) begin
        src_valid <= 1'b1;
        src_byte  <= comp_q[0].b;
        src_last  <= comp_q[0].last;
        comp_q.pop_front();
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // long hold-off on request so the block backs up into its input
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      snk_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      snk_ready <= 1'b0;
    end else begin
      snk_ready <= ($urandom_range(99) >= snk_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (comp_ch.valid && comp_ch.ready) || (decomp_ch.valid && decomp_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("lzss_stream_decompressor verification failed");
        $finish;
      end
    end
  end

  task automatic send(input logic [7:0] b, input logic last);
    comp_item_t it;
    it.b    = b;
    it.last = last;
    comp_q.push_back(it);
  endtask

  task automatic queue_blob(input blob_kind_t kind, input cnt_t size);
    logic [7:0]  blob [$];
    logic [63:0] hdr;
    logic [7:0]  flag;
    logic [11:0] pos;
    int          end_at;
    int          produced;
    int          items;
    int          len_n;
    int          d;
    hdr = {MAGIC_L, MAGIC_Z, MAGIC_S, MAGIC_S, size};
    for (int i = 0; i < 8; i++) blob.push_back(hdr[63 - 8*i -: 8]);
    produced = 0;
    items    = 0;
    if (kind != BLOB_ZERO) begin
      while (produced < size && items < MAX_BODY_ITEMS) begin
        flag = 8'($urandom_range(255));
        blob.push_back(flag);
        for (int k = 0; k < 8 && produced < size && items < MAX_BODY_ITEMS; k++) begin
          if (flag[k]) begin
            blob.push_back(8'($urandom_range(255)));
            produced++;
          end else begin
            len_n = $urandom_range(15);
            if (produced > 0 && $urandom_range(3) != 0) begin
              d   = $urandom_range(1, (produced > 4095) ? 4095 : produced);
              pos = 12'(produced - d);
            end else begin
              pos = 12'($urandom_range(4095));
            end
            blob.push_back(pos[7:0]);
            blob.push_back({pos[11:8], 4'(len_n)});
            produced += len_n + 3;
          end
          items++;
        end
      end
    end
    end_at = blob.size() - 1;
    case (kind)
      BLOB_CUT: end_at = $urandom_range(end_at);
      BLOB_BAD_MAGIC: begin
        blob[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
        repeat ($urandom_range(4)) blob.push_back(8'($urandom));
        end_at = blob.size() - 1;
      end
      BLOB_GOOD: begin
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 5)) blob.push_back(8'($urandom));
          end_at = blob.size() - 1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i <= end_at; i++) send(blob[i], i == end_at);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (comp_q.size() != 0 || src_valid) @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : run
    cnt_t       lim;
    cnt_t       size;
    blob_kind_t kind;
    int         r;
    int         sent;
    int         q_mark;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // literal extremes, pair at top of window, max-length pair overshooting the size
    send(MAGIC_L, 1'b0);
    send(MAGIC_Z, 1'b0);
    send(MAGIC_S, 1'b0);
    send(MAGIC_S, 1'b0);
    send(8'h00, 1'b0);
    send(8'h00, 1'b0);
    send(8'h00, 1'b0);
    send(8'h14, 1'b0);
    send(8'h05, 1'b0);
    send(8'hFF, 1'b0);
    send(8'hFF, 1'b0);
    send(8'hF0, 1'b0);
    send(8'h00, 1'b0);
    send(8'h00, 1'b0);
    send(8'h0F, 1'b1);
    // bad magic, then trailing item carrying in_last
    send(8'h58, 1'b0);
    send(8'hFF, 1'b1);
    queue_blob(BLOB_ZERO, '0);
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       lim = '1;
        1:       lim = '0;
        2:       lim = $urandom_range(8, 30);
        3:       lim = 32'd1;
        4:       lim = 32'hFFFF_FFFE;
        5:       lim = $urandom_range(20, 60);
        6:       lim = '1;
        default: lim = $urandom_range(2, 16);
      endcase
      @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= lim;
      case (p % 4)
        0: begin src_pct <= 0;  snk_pct <= 0;  end
        1: begin src_pct <= 52; snk_pct <= 0;  end
        2: begin src_pct <= 0;  snk_pct <= 52; end
        default: begin src_pct <= 7; snk_pct <= 7; end
      endcase
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      if (p == 2) hold_req <= hold_req + 1;
      @(negedge clk);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        r    = $urandom_range(99);
        kind = (r < 62) ? BLOB_GOOD : (r < 78) ? BLOB_CUT : (r < 90) ? BLOB_BAD_MAGIC : BLOB_ZERO;
        if (kind == BLOB_ZERO) size = '0;
        else if (kind == BLOB_CUT && $urandom_range(2) == 0) size = $urandom;
        else if (lim < 64 && $urandom_range(1) == 0) size = $urandom_range(1) ? lim : lim + 1;
        else size = $urandom_range(1, 40);
        q_mark = comp_q.size();
        queue_blob(kind, size);
        sent += comp_q.size() - q_mark;
      end
      wait_idle();
    end

    if (errors == 0 && pending == 0) begin
      $display("lzss_stream_decompressor verification clean");
    end else begin
      $display("lzss_stream_decompressor verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/lzsd_pkg.sv
src/lzsd_if.sv
src/lzsd_ctrl.sv
src/lzsd_datapath.sv
src/lzss_stream_decompressor.sv
tb/sv/lzsd_decode_checker.sv
tb/sv/lzss_stream_decompressor_tb.sv
